>>> rtl/pmte_pkg.sv
// Package: shared constants and types of the pixel matrix transform engine.
`timescale 1ns / 1ps
package pmte_pkg;

  localparam int MAX_DIM_DEF = 32;
  localparam int ACT_W       = 4;
  localparam int ARG_W       = 6;
  localparam int PIX_W       = 8;

  // Command codes carried in the action field.
  typedef enum logic [ACT_W-1:0] {
    ACT_SIZE    = 4'd0,
    ACT_WRITE   = 4'd1,
    ACT_READ    = 4'd2,
    ACT_ROTL    = 4'd3,
    ACT_ROTR    = 4'd4,
    ACT_SHL     = 4'd5,
    ACT_SHR     = 4'd6,
    ACT_SHU     = 4'd7,
    ACT_SHD     = 4'd8,
    ACT_TRL     = 4'd9,
    ACT_TRR     = 4'd10,
    ACT_TRT     = 4'd11,
    ACT_TRB     = 4'd12,
    ACT_FILLROW = 4'd13,
    ACT_FILLCOL = 4'd14,
    ACT_FILLALL = 4'd15
  } act_t;

  // How a sweep finds the source pixel of each destination pixel.
  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_MOVE,
    KIND_ROTL,
    KIND_ROTR
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

>>> rtl/pmte_if.sv
// Interfaces: command channel and result channel of the engine.
`timescale 1ns / 1ps
interface pmte_in_if;
  logic                           valid;
  logic                           ready;
  logic [pmte_pkg::ACT_W-1:0]     action;
  logic [pmte_pkg::ARG_W-1:0]     col_arg;
  logic [pmte_pkg::ARG_W-1:0]     row_arg;
  logic [pmte_pkg::PIX_W-1:0]     pixel_in;

  modport source (output valid, action, col_arg, row_arg, pixel_in, input ready);
  modport sink   (input valid, action, col_arg, row_arg, pixel_in, output ready);
endinterface

interface pmte_out_if;
  logic                           valid;
  logic                           ready;
  logic [pmte_pkg::PIX_W-1:0]     pixel_out;
  logic [pmte_pkg::ARG_W-1:0]     width_now;
  logic [pmte_pkg::ARG_W-1:0]     height_now;
  logic                           is_empty;

  modport source (output valid, pixel_out, width_now, height_now, is_empty, input ready);
  modport sink   (input valid, pixel_out, width_now, height_now, is_empty, output ready);
endinterface

>>> rtl/pixel_matrix_transform_engine.sv
// Top level: LED matrix store with size, pixel, rotate, shift, trim and fill commands.
`timescale 1ns / 1ps
// Usage:
// Commands arrive on in_ch (valid/ready); each accepted transaction yields
// exactly one result transaction on out_ch with the pixel read (zero unless
// the command was a read), the new width and height, and an empty flag.
// Every command is carried out as one sweep over all MAX_DIM*MAX_DIM pixel
// positions: the source image is read from one of two ping-pong memories
// and the new image is written to the other, one pixel per cycle. The
// single read port of the source memory sets the pace. After the sweep come
// a drain state and a done state; the result is registered as the engine
// returns to idle, and only then can the next command be accepted, so no
// new command is taken while a sweep is under way.
// The bounding box of the nonzero pixels is gathered during the sweep, so
// trims know their cut at once and need no separate scan.
// Reset clears the size to zero and needs no clearing pass: pixels outside
// the current size are never taken from memory, and the first sweep
// rewrites its whole destination memory.
// A result waits in the output register while the receiver stalls; the
// next command is taken meanwhile and its result waits until the slot frees.
module pixel_matrix_transform_engine #(
  parameter int MAX_DIM = pmte_pkg::MAX_DIM_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  pmte_in_if.sink       in_ch,
  pmte_out_if.source    out_ch
);
  import pmte_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_DIM);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int SW    = DW + 2;
  localparam int EW    = ARG_W + 1;
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_DIM);
  localparam logic [CW-1:0] LAST_IDX   = CW'(MAX_DIM - 1);
  localparam logic [EW-1:0] MAX_E      = EW'(MAX_DIM);

  // Ping-pong pixel memories.
  logic [PIX_W-1:0] mem_a [DEPTH];
  logic [PIX_W-1:0] mem_b [DEPTH];
  logic [PIX_W-1:0] rd_a_r, rd_b_r;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [PIX_W-1:0] wr_data;
  logic             wr_en;

  state_t state_r, state_nxt;
  logic   sel_r;

  // Matrix shape and bounding box of the nonzero pixels.
  logic [DW-1:0] w_r, h_r;
  logic          any_r;
  logic [CW-1:0] minx_r, maxx_r, miny_r, maxy_r;

  // Command held for the sweep.
  act_t                act_r;
  kind_t               kind_r;
  logic [ARG_W-1:0]    cx_r, ry_r;
  logic [PIX_W-1:0]    d_r;
  logic [DW-1:0]       nw_r, nh_r;
  logic signed [SW-1:0] dx_r, dy_r;

  // Sweep counters and the stage that writes.
  logic [CW-1:0] x_r, y_r;
  logic          s1_v_r, s1_src_r;
  logic [CW-1:0] s1_x_r, s1_y_r;
  logic [PIX_W-1:0] pix_r;

  // Result register.
  logic             out_v_r;
  logic [PIX_W-1:0] o_pix_r;
  logic [ARG_W-1:0] o_w_r, o_h_r;
  logic             o_emp_r;

  logic in_acc, done_go, all_zero;
  kind_t               kind_c;
  logic [DW-1:0]       nw_c, nh_c, sw_c, sh_c;
  logic signed [SW-1:0] dx_c, dy_c;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign all_zero = (w_r == '0) || !any_r;
  assign done_go  = (state_r == ST_DONE) && (!out_v_r || out_ch.ready);

  // Saturated size for the size command.
  always_comb begin
    sw_c = ({1'b0, in_ch.col_arg} > MAX_E) ? DW'(MAX_DIM) : DW'({1'b0, in_ch.col_arg});
    sh_c = ({1'b0, in_ch.row_arg} > MAX_E) ? DW'(MAX_DIM) : DW'({1'b0, in_ch.row_arg});
    if (sw_c == '0 || sh_c == '0) begin
      sw_c = '0;
      sh_c = '0;
    end
  end

  // Decode a command into a sweep: new shape, source mapping and offset.
  always_comb begin
    kind_c = KIND_MOVE;
    nw_c   = w_r;
    nh_c   = h_r;
    dx_c   = '0;
    dy_c   = '0;
    case (act_t'(in_ch.action))
      ACT_SIZE: begin
        kind_c = KIND_ZERO;
        nw_c   = sw_c;
        nh_c   = sh_c;
      end
      ACT_ROTL, ACT_ROTR: begin
        if (!all_zero) begin
          kind_c = (act_t'(in_ch.action) == ACT_ROTL) ? KIND_ROTL : KIND_ROTR;
          nw_c   = h_r;
          nh_c   = w_r;
        end
      end
      ACT_SHL: if (!all_zero) dx_c = SW'(1);
      ACT_SHR: if (!all_zero) dx_c = -SW'(1);
      ACT_SHU: if (!all_zero) dy_c = SW'(1);
      ACT_SHD: if (!all_zero) dy_c = -SW'(1);
      ACT_TRL, ACT_TRR, ACT_TRT, ACT_TRB: begin
        if (all_zero) begin
          kind_c = KIND_ZERO;
          nw_c   = '0;
          nh_c   = '0;
        end else begin
          case (act_t'(in_ch.action))
            ACT_TRL: begin
              dx_c = SW'(minx_r);
              nw_c = w_r - DW'(minx_r);
            end
            ACT_TRR: nw_c = DW'(maxx_r) + DW'(1);
            ACT_TRT: begin
              dy_c = SW'(miny_r);
              nh_c = h_r - DW'(miny_r);
            end
            default: nh_c = DW'(maxy_r) + DW'(1);
          endcase
        end
      end
      default: ;
    endcase
  end

  // Source coordinates of the destination pixel at the sweep counters.
  logic signed [SW-1:0] xs, ys, ws, hs, sx, sy;
  logic                 src_ok;
  always_comb begin
    xs = $signed(SW'(x_r));
    ys = $signed(SW'(y_r));
    ws = $signed(SW'(w_r));
    hs = $signed(SW'(h_r));
    case (kind_r)
      KIND_ROTL: begin
        sx = ws - ys - SW'(1);
        sy = xs;
      end
      KIND_ROTR: begin
        sx = ys;
        sy = hs - xs - SW'(1);
      end
      default: begin
        sx = xs + dx_r;
        sy = ys + dy_r;
      end
    endcase
    src_ok  = (kind_r != KIND_ZERO) && (sx >= 0) && (sy >= 0) && (sx < ws) && (sy < hs);
    rd_addr = AW'(sy[CW-1:0]) * ROW_STRIDE + AW'(sx[CW-1:0]);
  end

  // New pixel value in the write stage.
  logic [PIX_W-1:0] src_pix;
  logic             in_new, hit_xy;
  always_comb begin
    src_pix = s1_src_r ? (sel_r ? rd_b_r : rd_a_r) : '0;
    in_new  = (DW'(s1_x_r) < nw_r) && (DW'(s1_y_r) < nh_r);
    hit_xy  = (EW'(s1_x_r) == EW'(cx_r)) && (EW'(s1_y_r) == EW'(ry_r));
    wr_data = src_pix;
    case (act_r)
      ACT_WRITE:   if (hit_xy) wr_data = d_r;
      ACT_FILLROW: if (EW'(s1_y_r) == EW'(ry_r)) wr_data = d_r;
      ACT_FILLCOL: if (EW'(s1_x_r) == EW'(cx_r)) wr_data = d_r;
      ACT_FILLALL: wr_data = d_r;
      default: ;
    endcase
    if (!in_new) wr_data = '0;
    wr_en   = s1_v_r;
    wr_addr = AW'(s1_y_r) * ROW_STRIDE + AW'(s1_x_r);
  end

  // Memory A: destination when the current image sits in B.
  always_ff @(posedge clk) begin
    if (wr_en && sel_r) mem_a[wr_addr] <= wr_data;
    rd_a_r <= mem_a[rd_addr];
  end

  // Memory B: destination when the current image sits in A.
  always_ff @(posedge clk) begin
    if (wr_en && !sel_r) mem_b[wr_addr] <= wr_data;
    rd_b_r <= mem_b[rd_addr];
  end

  // Next state and handshake.
  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_SWEEP;
      ST_SWEEP: if (x_r == LAST_IDX && y_r == LAST_IDX) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE:  if (done_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Command capture, sweep counters and write stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= (state_r == ST_SWEEP);
    end
    s1_x_r   <= x_r;
    s1_y_r   <= y_r;
    s1_src_r <= src_ok;
    if (in_acc) begin
      act_r  <= act_t'(in_ch.action);
      kind_r <= kind_c;
      cx_r   <= in_ch.col_arg;
      ry_r   <= in_ch.row_arg;
      d_r    <= in_ch.pixel_in;
      nw_r   <= nw_c;
      nh_r   <= nh_c;
      dx_r   <= dx_c;
      dy_r   <= dy_c;
      x_r    <= '0;
      y_r    <= '0;
      pix_r  <= '0;
    end else if (state_r == ST_SWEEP) begin
      if (x_r == LAST_IDX) begin
        x_r <= '0;
        y_r <= y_r + CW'(1);
      end else begin
        x_r <= x_r + CW'(1);
      end
    end
    if (s1_v_r && act_r == ACT_READ && hit_xy && in_new) pix_r <= src_pix;
  end

  // Shape, bounding box and memory select.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
      w_r   <= '0;
      h_r   <= '0;
      any_r <= 1'b0;
    end else begin
      if (in_acc) begin
        any_r  <= 1'b0;
        minx_r <= LAST_IDX;
        miny_r <= LAST_IDX;
        maxx_r <= '0;
        maxy_r <= '0;
      end else if (s1_v_r && wr_data != '0) begin
        any_r <= 1'b1;
        if (s1_x_r < minx_r) minx_r <= s1_x_r;
        if (s1_x_r > maxx_r) maxx_r <= s1_x_r;
        if (s1_y_r < miny_r) miny_r <= s1_y_r;
        if (s1_y_r > maxy_r) maxy_r <= s1_y_r;
      end
      if (done_go) begin
        sel_r <= !sel_r;
        w_r   <= nw_r;
        h_r   <= nh_r;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (done_go) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
    if (done_go) begin
      o_pix_r <= pix_r;
      o_w_r   <= ARG_W'(EW'(nw_r));
      o_h_r   <= ARG_W'(EW'(nh_r));
      o_emp_r <= (nw_r == '0) || !any_r;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.pixel_out  = o_pix_r;
  assign out_ch.width_now  = o_w_r;
  assign out_ch.height_now = o_h_r;
  assign out_ch.is_empty   = o_emp_r;

endmodule

>>> rtl/pmte_checker.sv
// Checker: port-level properties of the engine, bound to the top level.
`timescale 1ns / 1ps
module pmte_checker #(
  parameter int MAX_DIM = pmte_pkg::MAX_DIM_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pmte_pkg::PIX_W-1:0]    pixel_out,
  input logic [pmte_pkg::ARG_W-1:0]    width_now,
  input logic [pmte_pkg::ARG_W-1:0]    height_now,
  input logic                          is_empty
);
  import pmte_pkg::*;

  localparam bit FULL_RANGE = (MAX_DIM < 64);

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(width_now)
      && $stable(height_now) && $stable(is_empty))
    else $error("result changed while stalled");

  // One command at a time: after acceptance the input closes.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken during a sweep");

  // Width and height are zero together.
  a_zero_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && FULL_RANGE |-> ((width_now == '0) == (height_now == '0)))
    else $error("only one dimension is zero");

  // A zero-size matrix reports empty.
  a_zero_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && FULL_RANGE && width_now == '0 |-> is_empty)
    else $error("zero-size matrix not reported empty");

endmodule

bind pixel_matrix_transform_engine pmte_checker #(.MAX_DIM(MAX_DIM)) u_pmte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .pixel_out  (out_ch.pixel_out),
  .width_now  (out_ch.width_now),
  .height_now (out_ch.height_now),
  .is_empty   (out_ch.is_empty)
);

>>> verif/pixel_matrix_transform_engine_tb.sv
// Testbench: drives matrix commands with random timing and checks every result.
`timescale 1ns / 1ps
module pixel_matrix_transform_engine_tb;
  import pmte_pkg::*;

  localparam int DIM       = MAX_DIM_DEF;
  localparam int CELLS     = DIM * DIM;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 1100;
  localparam int RAND_CMDS  = 270;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [ARG_W-1:0] width;
    logic [ARG_W-1:0] height;
    logic             empty;
  } matrix_result_t;

  // Shadow copy of the matrix and the queue of results it predicts.
  class matrix_scoreboard;
    logic [PIX_W-1:0] img[CELLS];
    int unsigned      mw;
    int unsigned      mh;
    matrix_result_t   pending[$];
    int               mismatches;

    function new();
      foreach (img[i]) img[i] = '0;
      mw = 0;
      mh = 0;
      mismatches = 0;
    endfunction

    function bit blank();
      if (mw == 0 || mh == 0) return 1;
      foreach (img[i]) if (img[i] != 0) return 0;
      return 1;
    endfunction

    // New image: new(x,y) = old(x+dx, y+dy), zero where the source is off the matrix.
    function void relocate(int dx, int dy, int unsigned nw, int unsigned nh);
      logic [PIX_W-1:0] tmp[CELLS];
      int sx, sy;
      foreach (tmp[i]) tmp[i] = '0;
      for (int y = 0; y < int'(nh); y++)
        for (int x = 0; x < int'(nw); x++) begin
          sx = x + dx;
          sy = y + dy;
          if (sx >= 0 && sy >= 0 && sx < int'(mw) && sy < int'(mh))
            tmp[y*DIM + x] = img[sy*DIM + sx];
        end
      img = tmp;
      mw = nw;
      mh = nh;
    endfunction

    function void turn(bit left);
      logic [PIX_W-1:0] tmp[CELLS];
      int unsigned w, h;
      w = mw;
      h = mh;
      foreach (tmp[i]) tmp[i] = '0;
      for (int unsigned y = 0; y < h; y++)
        for (int unsigned x = 0; x < w; x++)
          if (left) tmp[(w-1-x)*DIM + y] = img[y*DIM + x];
          else      tmp[x*DIM + (h-1-y)] = img[y*DIM + x];
      img = tmp;
      mw = h;
      mh = w;
    endfunction

    function bit col_blank(int unsigned x);
      for (int unsigned y = 0; y < mh; y++) if (img[y*DIM + x] != 0) return 0;
      return 1;
    endfunction

    function bit row_blank(int unsigned y);
      for (int unsigned x = 0; x < mw; x++) if (img[y*DIM + x] != 0) return 0;
      return 1;
    endfunction

    function void crop(act_t a);
      int unsigned k;
      k = 0;
      if (blank()) begin
        foreach (img[i]) img[i] = '0;
        mw = 0;
        mh = 0;
        return;
      end
      case (a)
        ACT_TRL: begin
          while (k < mw && col_blank(k)) k++;
          relocate(k, 0, mw - k, mh);
        end
        ACT_TRR: begin
          while (k < mw && col_blank(mw - 1 - k)) k++;
          relocate(0, 0, mw - k, mh);
        end
        ACT_TRT: begin
          while (k < mh && row_blank(k)) k++;
          relocate(0, k, mw, mh - k);
        end
        default: begin
          while (k < mh && row_blank(mh - 1 - k)) k++;
          relocate(0, 0, mw, mh - k);
        end
      endcase
    endfunction

    // Apply one accepted command and queue the result it should produce.
    function void note_command(act_t a, logic [ARG_W-1:0] cx, logic [ARG_W-1:0] ry,
                               logic [PIX_W-1:0] d);
      matrix_result_t r;
      bit on_grid;
      int unsigned w, h;
      r.pixel = '0;
      on_grid = cx < mw && ry < mh;
      case (a)
        ACT_SIZE: begin
          w = cx > DIM ? DIM : cx;
          h = ry > DIM ? DIM : ry;
          if (w == 0 || h == 0) begin
            w = 0;
            h = 0;
          end
          foreach (img[i]) img[i] = '0;
          mw = w;
          mh = h;
        end
        ACT_WRITE: if (on_grid) img[ry*DIM + cx] = d;
        ACT_READ: if (on_grid) r.pixel = img[ry*DIM + cx];
        ACT_ROTL, ACT_ROTR: if (!blank()) turn(a == ACT_ROTL);
        ACT_SHL: if (!blank()) relocate(1, 0, mw, mh);
        ACT_SHR: if (!blank()) relocate(-1, 0, mw, mh);
        ACT_SHU: if (!blank()) relocate(0, 1, mw, mh);
        ACT_SHD: if (!blank()) relocate(0, -1, mw, mh);
        ACT_TRL, ACT_TRR, ACT_TRT, ACT_TRB: crop(a);
        ACT_FILLROW: if (ry < mh) for (int unsigned i = 0; i < mw; i++) img[ry*DIM + i] = d;
        ACT_FILLCOL: if (cx < mw) for (int unsigned i = 0; i < mh; i++) img[i*DIM + cx] = d;
        default: begin
          for (int unsigned y = 0; y < mh; y++)
            for (int unsigned x = 0; x < mw; x++) img[y*DIM + x] = d;
        end
      endcase
      r.width  = mw[ARG_W-1:0];
      r.height = mh[ARG_W-1:0];
      r.empty  = blank();
      pending.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(matrix_result_t got);
      matrix_result_t exp_r;
      if (pending.size() == 0) begin
        report_mismatch("result transaction with no command outstanding");
        return;
      end
      exp_r = pending.pop_front();
      if (got.pixel != exp_r.pixel)
        report_mismatch($sformatf("pixel_out %0d, expected %0d", got.pixel, exp_r.pixel));
      if (got.width != exp_r.width)
        report_mismatch($sformatf("width_now %0d, expected %0d", got.width, exp_r.width));
      if (got.height != exp_r.height)
        report_mismatch($sformatf("height_now %0d, expected %0d", got.height, exp_r.height));
      if (got.empty != exp_r.empty)
        report_mismatch($sformatf("is_empty %0d, expected %0d", got.empty, exp_r.empty));
    endtask
  endclass

  logic clk;
  logic rst_n;
  pmte_in_if  in_ch();
  pmte_out_if out_ch();
  matrix_scoreboard board;
  bit stall_long;
  int idle_cycles;

  pixel_matrix_transform_engine u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Clock: 2 ns period.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random stalls in runs, plus one long hold-off when requested.
  initial begin
    int hold;
    bit long_done;
    long_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_long && !long_done) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        long_done = 1'b1;
      end
      hold = $urandom_range(0, 9);
      if (hold < 3) begin
        out_ch.ready <= 1'b1;
      end else if (hold < 7) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result({out_ch.pixel_out, out_ch.width_now, out_ch.height_now,
                          out_ch.is_empty});
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one command and hold it until the engine takes it.
  task send_command(act_t a, logic [ARG_W-1:0] cx, logic [ARG_W-1:0] ry,
                    logic [PIX_W-1:0] d);
    in_ch.valid    <= 1'b1;
    in_ch.action   <= a;
    in_ch.col_arg  <= cx;
    in_ch.row_arg  <= ry;
    in_ch.pixel_in <= d;
    do @(posedge clk); while (!in_ch.ready);
    board.note_command(a, cx, ry, d);
  endtask

  // Between bursts the sender drops valid for a random gap.
  task sender_pause();
    if ($urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  task send_random();
    int pick;
    logic [ARG_W-1:0] cx, ry;
    act_t a;
    pick = $urandom_range(0, 99);
    cx = ARG_W'($urandom_range(0, 7));
    ry = ARG_W'($urandom_range(0, 7));
    if ($urandom_range(0, 9) == 0) begin
      cx = ARG_W'($urandom_range(0, 63));
      ry = ARG_W'($urandom_range(0, 63));
    end
    if (pick < 8) begin
      a = ACT_SIZE;
      cx = ARG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                               : $urandom_range(1, 6));
      ry = ARG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                               : $urandom_range(1, 6));
    end else if (pick < 35) a = ACT_WRITE;
    else if (pick < 50) a = ACT_READ;
    else if (pick < 92) a = act_t'($urandom_range(3, 15));
    else a = $urandom_range(0, 1) ? ACT_FILLROW : ACT_FILLCOL;
    send_command(a, cx, ry, $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(0, 255)));
  endtask

  initial begin
    board = new();
    stall_long = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_SIZE;
    in_ch.col_arg = '0;
    in_ch.row_arg = '0;
    in_ch.pixel_in = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-matrix operations, size extremes, every command.
    send_command(ACT_ROTL, 0, 0, 0);
    send_command(ACT_TRL, 0, 0, 0);
    send_command(ACT_SIZE, 63, 63, 0);
    send_command(ACT_WRITE, 31, 31, 8'hFF);
    send_command(ACT_READ, 31, 31, 0);
    send_command(ACT_WRITE, 32, 0, 8'h55);
    send_command(ACT_READ, 63, 63, 0);
    send_command(ACT_SIZE, 0, 5, 0);
    send_command(ACT_SHL, 0, 0, 0);
    send_command(ACT_SIZE, 4, 3, 0);
    send_command(ACT_FILLROW, 0, 5, 8'h11);
    send_command(ACT_FILLCOL, 9, 0, 8'h22);
    send_command(ACT_WRITE, 1, 1, 8'hAA);
    send_command(ACT_ROTL, 0, 0, 0);
    send_command(ACT_ROTR, 0, 0, 0);
    send_command(ACT_SHL, 0, 0, 0);
    send_command(ACT_SHR, 0, 0, 0);
    send_command(ACT_SHU, 0, 0, 0);
    send_command(ACT_SHD, 0, 0, 0);
    send_command(ACT_TRL, 0, 0, 0);
    send_command(ACT_TRR, 0, 0, 0);
    send_command(ACT_TRT, 0, 0, 0);
    send_command(ACT_TRB, 0, 0, 0);
    send_command(ACT_FILLALL, 0, 0, 8'h00);
    send_command(ACT_TRB, 0, 0, 0);

    // Random commands, with one long receiver hold-off in the middle.
    for (int n = 0; n < RAND_CMDS; n++) begin
      if (n == RAND_CMDS / 2) stall_long = 1'b1;
      send_random();
      sender_pause();
    end
    in_ch.valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
